@@ rtl/rfscd_pkg.sv @@
`default_nettype none
package rfscd_pkg;

  localparam int unsigned FRAME_BYTES = 21;
  localparam int unsigned FILL_W      = 5;
  localparam int unsigned CRC_AT      = 19;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [7:0]  HDR0      = 8'hA9;
  localparam logic [7:0]  HDR1      = 8'h53;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  localparam logic [10:0] CENTER_RESET  = 11'd1024;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_STICK_CENTER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONLINE_TIMEOUT = 2'd1;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic               frame_done;
    logic               online;
    logic signed [11:0] stick_a;
    logic signed [11:0] stick_b;
    logic signed [11:0] stick_c;
    logic signed [11:0] stick_d;
    logic signed [11:0] dial_value;
    logic [8:0]         switch_bits;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [15:0] mouse_wheel;
    logic [15:0]        key_bits;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CRC,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept_byte;
    logic accept_tick;
    logic drop;
    logic crc_start;
    logic crc_step;
    logic decode;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              hdr_ok;
    logic              crc_last;
    logic              crc_match;
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/rfscd_ctrl.sv @@
`default_nettype none
module rfscd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_is_tick,
  output logic                       in_stall,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  input  wire rfscd_pkg::dp_status_t st,
  output rfscd_pkg::dp_cmd_t         cmd
);

  rfscd_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic out_free;

  assign accept   = in_valid && (state_r == rfscd_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rfscd_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_is_tick == rfscd_pkg::CMD_TICK) ? rfscd_pkg::ST_DONE
                                                          : rfscd_pkg::ST_SCAN;
        end
      end
      rfscd_pkg::ST_SCAN: begin
        priority if (st.fill < 2) begin
          state_nxt = rfscd_pkg::ST_DONE;
        end else if (!st.hdr_ok) begin
          state_nxt = rfscd_pkg::ST_SCAN;
        end else if (st.fill == rfscd_pkg::FILL_W'(rfscd_pkg::FRAME_BYTES)) begin
          state_nxt = rfscd_pkg::ST_CRC;
        end else begin
          state_nxt = rfscd_pkg::ST_DONE;
        end
      end
      rfscd_pkg::ST_CRC: begin
        if (st.crc_last) state_nxt = rfscd_pkg::ST_CHECK;
      end
      rfscd_pkg::ST_CHECK: begin
        state_nxt = st.crc_match ? rfscd_pkg::ST_DONE : rfscd_pkg::ST_SCAN;
      end
      rfscd_pkg::ST_DONE: begin
        if (out_free) state_nxt = rfscd_pkg::ST_IDLE;
      end
      default: state_nxt = rfscd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      rfscd_pkg::ST_IDLE: begin
        in_stall        = 1'b0;
        cmd.accept_byte = in_valid && (in_is_tick == rfscd_pkg::CMD_BYTE);
        cmd.accept_tick = in_valid && (in_is_tick == rfscd_pkg::CMD_TICK);
      end
      rfscd_pkg::ST_SCAN: begin
        if (st.fill >= 2) begin
          // drop the leading byte until the header lines up
          cmd.drop      = !st.hdr_ok;
          cmd.crc_start = st.hdr_ok &&
                          (st.fill == rfscd_pkg::FILL_W'(rfscd_pkg::FRAME_BYTES));
        end
      end
      rfscd_pkg::ST_CRC: begin
        cmd.crc_step = 1'b1;
      end
      rfscd_pkg::ST_CHECK: begin
        cmd.decode = st.crc_match;
        cmd.drop   = !st.crc_match;
      end
      rfscd_pkg::ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfscd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ rtl/rfscd_datapath.sv @@
`default_nettype none
module rfscd_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire rfscd_pkg::dp_cmd_t                   cmd,
  output rfscd_pkg::dp_status_t                     st,
  input  wire logic [7:0]                           in_byte,
  input  wire logic                                 cfg_we,
  input  wire logic [rfscd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rfscd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output rfscd_pkg::out_t                           out_data
);

  localparam int unsigned NB = rfscd_pkg::FRAME_BYTES;

  logic [7:0] win_r [NB];
  logic [7:0] win_nxt [NB];
  logic [rfscd_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [rfscd_pkg::FILL_W-1:0] idx_r, idx_nxt;
  logic [10:0] center_r, center_nxt;
  logic [15:0] timeout_r, timeout_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic seen_r, seen_nxt;
  logic done_r, done_nxt;
  rfscd_pkg::out_t hold_r, hold_nxt;
  rfscd_pkg::out_t out_r, out_nxt;
  logic [8*NB-1:0] frame;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] x;
    x = c ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      x = x[0] ? ((x >> 1) ^ rfscd_pkg::CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  function automatic logic signed [11:0] centered(input logic [10:0] raw,
                                                  input logic [10:0] ctr);
    return $signed({1'b0, raw} - {1'b0, ctr});
  endfunction

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      frame[8*i +: 8] = win_r[i];
    end
  end

  assign st.fill      = fill_r;
  assign st.hdr_ok    = (win_r[0] == rfscd_pkg::HDR0) && (win_r[1] == rfscd_pkg::HDR1);
  assign st.crc_last  = (idx_r == rfscd_pkg::FILL_W'(rfscd_pkg::CRC_AT - 1));
  assign st.crc_match = (crc_r == {win_r[rfscd_pkg::CRC_AT + 1], win_r[rfscd_pkg::CRC_AT]});

  // window and fill count
  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (cmd.accept_byte) begin
      if (fill_r == rfscd_pkg::FILL_W'(NB)) begin
        for (int i = 0; i < NB - 1; i++) win_nxt[i] = win_r[i+1];
        win_nxt[NB-1] = in_byte;
      end else begin
        win_nxt[fill_r] = in_byte;
        fill_nxt        = fill_r + 1'b1;
      end
    end
    if (cmd.drop) begin
      for (int i = 0; i < NB - 1; i++) win_nxt[i] = win_r[i+1];
      fill_nxt = fill_r - 1'b1;
    end
    if (cmd.decode) begin
      fill_nxt = '0;
    end
  end

  // byte-serial CRC
  always_comb begin
    crc_nxt = crc_r;
    idx_nxt = idx_r;
    if (cmd.crc_start) begin
      crc_nxt = rfscd_pkg::CRC_INIT;
      idx_nxt = '0;
    end else if (cmd.crc_step) begin
      crc_nxt = crc_byte(crc_r, win_r[idx_r]);
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    center_nxt  = center_r;
    timeout_nxt = timeout_r;
    if (cfg_we) begin
      if (cfg_index == rfscd_pkg::REG_STICK_CENTER) begin
        center_nxt = cfg_data[10:0];
      end else if (cfg_index == rfscd_pkg::REG_ONLINE_TIMEOUT) begin
        timeout_nxt = cfg_data;
      end
    end
  end

  always_comb begin
    ticks_nxt = ticks_r;
    seen_nxt  = seen_r;
    done_nxt  = done_r;
    hold_nxt  = hold_r;
    if (cmd.accept_byte || cmd.accept_tick) begin
      done_nxt = 1'b0;
    end
    if (cmd.accept_tick && (ticks_r != rfscd_pkg::TICKS_MAX)) begin
      ticks_nxt = ticks_r + 1'b1;
    end
    if (cmd.decode) begin
      ticks_nxt = '0;
      seen_nxt  = 1'b1;
      done_nxt  = 1'b1;
      hold_nxt.stick_a     = centered(frame[26:16], center_r);
      hold_nxt.stick_b     = centered(frame[37:27], center_r);
      hold_nxt.stick_c     = centered(frame[48:38], center_r);
      hold_nxt.stick_d     = centered(frame[59:49], center_r);
      hold_nxt.dial_value  = centered(frame[75:65], center_r);
      hold_nxt.switch_bits = {|frame[133:132], |frame[131:130], |frame[129:128],
                              frame[76], frame[64], frame[63], frame[62], frame[61:60]};
      hold_nxt.mouse_dx    = $signed(frame[95:80]);
      hold_nxt.mouse_dy    = $signed(frame[111:96]);
      hold_nxt.mouse_wheel = $signed(frame[127:112]);
      hold_nxt.key_bits    = frame[151:136];
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.load_out) begin
      out_nxt            = hold_r;
      out_nxt.frame_done = done_r;
      out_nxt.online     = seen_r && (ticks_r < timeout_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      center_r  <= rfscd_pkg::CENTER_RESET;
      timeout_r <= rfscd_pkg::TIMEOUT_RESET;
      ticks_r   <= '0;
      seen_r    <= 1'b0;
      done_r    <= 1'b0;
      hold_r    <= '0;
    end else begin
      fill_r    <= fill_nxt;
      center_r  <= center_nxt;
      timeout_r <= timeout_nxt;
      ticks_r   <= ticks_nxt;
      seen_r    <= seen_nxt;
      done_r    <= done_nxt;
      hold_r    <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    crc_r <= crc_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

@@ rtl/remote_frame_sync_crc_decoder_unit.sv @@
`default_nettype none
// A tick goes from idle to the done state, which loads the output register once the
// output is free. A byte enters the header scan, which drops leading bytes (up to 20)
// until the header lines up; a full window then runs the byte-serial CRC (one window
// byte per cycle over 19 bytes) and its check; no new item is taken before idle.
// Reset (rst_n, synchronous, active low): empty window, no frame seen, held fields and
// tick count zero, registers at their defaults, no result pending.
module remote_frame_sync_crc_decoder_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire rfscd_pkg::in_t                      in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output rfscd_pkg::out_t                          out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rfscd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rfscd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rfscd_pkg::dp_cmd_t    cmd;
  rfscd_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  rfscd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_tick (in_data.cmd),
    .in_stall   (in_stall),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .st         (st),
    .cmd        (cmd)
  );

  rfscd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_byte   (in_data.rx_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous item still in progress");

  a_decode_on_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decode |-> (st.crc_match && st.hdr_ok &&
                    st.fill == rfscd_pkg::FILL_W'(rfscd_pkg::FRAME_BYTES)))
    else $error("decode without a full, matching window");

  a_crc_start_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.crc_start |-> (st.hdr_ok && st.fill == rfscd_pkg::FILL_W'(rfscd_pkg::FRAME_BYTES)))
    else $error("CRC started on a partial or misaligned window");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending output");
`endif

endmodule
`default_nettype wire
